[src/bcomp_pkg.sv]
package bcomp_pkg;

    // Divider word width (64-bit formula; the 32-bit formula is zero-extended)
    localparam int DIV_W = 64;

    // Configuration register indexes
    localparam logic [2:0] REG_TEMP_COEFFS = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW   = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH  = 3'd2;
    localparam logic [2:0] REG_PRESS_NINE  = 3'd3;
    localparam logic [2:0] REG_PRECISION   = 3'd4;

    // Per-item side data carried around the divider
    typedef struct packed {
        logic [31:0] temperature;
        logic [31:0] fine_temp;
        logic        zero;
        logic        dbl;
    } bcomp_side_t;

    // Arithmetic right shift of a 32-bit word
    function automatic logic [31:0] asr32(logic [31:0] x, int unsigned sh);
        logic signed [31:0] xs;
        xs = x;
        return xs >>> sh;
    endfunction

    // Arithmetic right shift of a 64-bit word
    function automatic logic [63:0] asr64(logic [63:0] x, int unsigned sh);
        logic signed [63:0] xs;
        xs = x;
        return xs >>> sh;
    endfunction

    // Sign-extend a 16-bit word to 32 bits
    function automatic logic [31:0] sx16_32(logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    // Sign-extend a 16-bit word to 64 bits
    function automatic logic [63:0] sx16_64(logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

endpackage

[src/bcomp_div.sv]
module bcomp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [bcomp_pkg::DIV_W-1:0]   num,
    input  logic [bcomp_pkg::DIV_W-1:0]   den,
    input  bcomp_pkg::bcomp_side_t        side_in,
    output logic                          out_valid,
    output logic [bcomp_pkg::DIV_W-1:0]   quo,
    output bcomp_pkg::bcomp_side_t        side_out
);
    import bcomp_pkg::*;

    logic [DIV_W-1:0] rem_reg  [DIV_W+1];
    logic [DIV_W-1:0] dq_reg   [DIV_W+1];
    logic [DIV_W-1:0] md_reg   [DIV_W+1];
    logic             neg_reg  [DIV_W+1];
    logic             vld_reg  [DIV_W+1];
    bcomp_side_t      side_reg [DIV_W+1];

    logic             out_vld_reg;
    logic [DIV_W-1:0] quo_reg;
    bcomp_side_t      side_out_reg;

    // Take magnitudes and the quotient sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= '0;
            dq_reg[0]   <= num[DIV_W-1] ? -num : num;
            md_reg[0]   <= den[DIV_W-1] ? -den : den;
            neg_reg[0]  <= num[DIV_W-1] ^ den[DIV_W-1];
            side_reg[0] <= side_in;
        end
    end

    // One restoring quotient bit per stage
    for (genvar k = 0; k < DIV_W; k++)
    begin : g_step
        logic [DIV_W:0] sh;
        logic [DIV_W:0] df;
        logic           ge;

        assign sh = {rem_reg[k], dq_reg[k][DIV_W-1]};
        assign df = sh - {1'b0, md_reg[k]};
        assign ge = ~df[DIV_W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= ge ? df[DIV_W-1:0] : sh[DIV_W-1:0];
                dq_reg[k+1]   <= {dq_reg[k][DIV_W-2:0], ge};
                md_reg[k+1]   <= md_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Apply the sign to the quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_reg[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo_reg      <= neg_reg[DIV_W] ? -dq_reg[DIV_W] : dq_reg[DIV_W];
            side_out_reg <= side_reg[DIV_W];
        end
    end

    assign out_valid = out_vld_reg;
    assign quo       = quo_reg;
    assign side_out  = side_out_reg;

endmodule

[src/barometric_sensor_compensation.sv]
// Pipeline: 8 front stages, a 66-stage radix-2 divider and 4 back stages.
// Throughput: one item per cycle while the output is not stalled; the divider
// takes one quotient bit per stage.
// A stall on the output freezes every stage at once; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits and every configuration
// register to zero; no clearing pass is needed.
module barometric_sensor_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // raw_temp [19:0], raw_press [39:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // temperature [31:0], fine_temp [63:32],
                                        // pressure [95:64]
    output logic [0:0]  m_axis_tuser    // press_invalid [0]
);
    import bcomp_pkg::*;

    // Configuration registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;
    logic        precision_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
            precision_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                REG_PRECISION:   precision_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Calibration words
    logic [15:0] t1, p1;
    logic signed [15:0] p2s, p3s, p5s, p6s, p8s, p9s;
    logic [31:0] t2x, t3x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;
    logic [63:0] p4x64, p7x64;

    assign t1    = temp_coeffs_reg[15:0];
    assign t2x   = sx16_32(temp_coeffs_reg[31:16]);
    assign t3x   = sx16_32(temp_coeffs_reg[47:32]);
    assign p1    = press_low_reg[15:0];
    assign p2s   = press_low_reg[31:16];
    assign p3s   = press_low_reg[47:32];
    assign p5s   = press_high_reg[15:0];
    assign p6s   = press_high_reg[31:16];
    assign p8s   = press_high_reg[63:48];
    assign p9s   = press_nine_reg;
    assign p2x   = sx16_32(press_low_reg[31:16]);
    assign p3x   = sx16_32(press_low_reg[47:32]);
    assign p4x   = sx16_32(press_low_reg[63:48]);
    assign p5x   = sx16_32(press_high_reg[15:0]);
    assign p6x   = sx16_32(press_high_reg[31:16]);
    assign p7x   = sx16_32(press_high_reg[47:32]);
    assign p8x   = sx16_32(press_high_reg[63:48]);
    assign p9x   = sx16_32(press_nine_reg);
    assign p4x64 = sx16_64(press_low_reg[63:48]);
    assign p7x64 = sx16_64(press_high_reg[47:32]);

    // Global advance: the whole pipe moves when the output slot is free or taken
    logic adv;
    logic out_vld_reg;
    logic [8:1] pre_vld_reg;
    logic [3:1] post_vld_reg;
    logic div_out_valid;

    assign adv           = ~out_vld_reg | m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= '0;
            post_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            pre_vld_reg  <= {pre_vld_reg[7:1], s_axis_tvalid};
            post_vld_reg <= {post_vld_reg[2:1], div_out_valid};
            out_vld_reg  <= post_vld_reg[3];
        end
    end

    // Stage 1: temperature products
    logic [19:0] adc_t, adc_p;
    logic [31:0] d1, d2, s1_m1_next, s1_m2_next;
    logic [31:0] s1_m1_reg, s1_m2_reg;
    logic [19:0] s1_adc_reg;

    assign adc_t      = s_axis_tdata[19:0];
    assign adc_p      = s_axis_tdata[39:20];
    assign d1         = {15'd0, adc_t[19:3]} - {15'd0, t1, 1'b0};
    assign d2         = {16'd0, adc_t[19:4]} - {16'd0, t1};
    assign s1_m1_next = d1 * t2x;
    assign s1_m2_next = d2 * d2;

    // Stage 2: second temperature product
    logic [31:0] s2_v1_next, s2_m3_next;
    logic [31:0] s2_v1_reg, s2_m3_reg;
    logic [19:0] s2_adc_reg;

    assign s2_v1_next = asr32(s1_m1_reg, 11);
    assign s2_m3_next = asr32(s1_m2_reg, 12) * t3x;

    // Stage 3: fine temperature
    logic [31:0] s3_tf_next, s3_tf_reg;
    logic [19:0] s3_adc_reg;

    assign s3_tf_next = s2_v1_reg + asr32(s2_m3_reg, 14);

    // Stage 4: temperature and first pressure products
    logic [63:0] a64;
    logic signed [32:0] as33;
    logic signed [65:0] aa_full;
    logic signed [48:0] ap5_full, ap2_full;
    logic [31:0] a32, q32;
    logic [31:0] s4_temp_next;
    logic [31:0] s4_temp_reg, s4_tf_reg;
    logic [63:0] s4_aa_reg, s4_ap5_reg, s4_ap2_reg;
    logic [31:0] s4_sq_reg, s4_ap5w_reg, s4_ap2w_reg;
    logic [19:0] s4_adc_reg;

    assign s4_temp_next = asr32(s3_tf_reg * 32'd5 + 32'd128, 8);
    assign a64          = {{32{s3_tf_reg[31]}}, s3_tf_reg} - 64'd128000;
    assign as33         = a64[32:0];
    assign aa_full      = as33 * as33;
    assign ap5_full     = as33 * p5s;
    assign ap2_full     = as33 * p2s;
    assign a32          = asr32(s3_tf_reg, 1) - 32'd64000;
    assign q32          = asr32(a32, 2);

    // Stage 5: quadratic terms
    logic signed [79:0] b_full, t_full5;
    logic [63:0] s5_b_next, s5_b_reg, s5_t_reg, s5_ap2_reg;
    logic [31:0] s5_bw_next, s5_tw_next, s5_bw_reg, s5_tw_reg, s5_ap2w_reg;
    logic [31:0] s5_temp_reg, s5_tf_reg;
    logic [19:0] s5_adc_reg;

    assign b_full     = $signed(s4_aa_reg) * p6s;
    assign t_full5    = $signed(s4_aa_reg) * p3s;
    assign s5_b_next  = b_full[63:0] + {s4_ap5_reg[46:0], 17'd0};
    assign s5_bw_next = asr32(s4_sq_reg, 11) * p6x + {s4_ap5w_reg[30:0], 1'b0};
    assign s5_tw_next = p3x * asr32(s4_sq_reg, 13);

    // Stage 6: offset and divisor precursors
    logic [63:0] s6_b_next, s6_x_next, s6_b_reg, s6_x_reg;
    logic [31:0] s6_bw_next, s6_xw_next, s6_bw_reg, s6_xw_reg;
    logic [31:0] s6_temp_reg, s6_tf_reg;
    logic [19:0] s6_adc_reg;

    assign s6_b_next  = s5_b_reg + {p4x64[28:0], 35'd0};
    assign s6_x_next  = 64'h0000_8000_0000_0000 + asr64(s5_t_reg, 8)
                        + {s5_ap2_reg[51:0], 12'd0};
    assign s6_bw_next = asr32(s5_bw_reg, 2) + {p4x[15:0], 16'd0};
    assign s6_xw_next = 32'd32768
                        + asr32(asr32(s5_tw_reg, 3) + asr32(s5_ap2w_reg, 1), 18);

    // Stage 7: divisor product and numerator base
    logic [20:0] pd21;
    logic [79:0] y_full;
    logic [63:0] s7_n_next, s7_y_reg, s7_n_reg;
    logic [31:0] s7_yw_next, s7_pw_next, s7_yw_reg, s7_pw_reg;
    logic [31:0] s7_temp_reg, s7_tf_reg;

    assign pd21       = 21'd1048576 - {1'b0, s6_adc_reg};
    assign y_full     = s6_x_reg * p1;
    assign s7_n_next  = {12'd0, pd21, 31'd0} - s6_b_reg;
    assign s7_yw_next = s6_xw_reg * {16'd0, p1};
    assign s7_pw_next = {11'd0, pd21} - asr32(s6_bw_reg, 12);

    // Stage 8: divider operands for the selected formula
    logic [63:0] den64, num64;
    logic [31:0] den32, n32, dvd32;
    logic        dbl8, zero8;
    logic [63:0] s8_num_reg, s8_den_reg;
    bcomp_side_t s8_side_next, s8_side_reg;

    assign den64  = asr64(s7_y_reg, 33);
    assign num64  = s7_n_reg * 64'd3125;
    assign den32  = asr32(s7_yw_reg, 15);
    assign n32    = s7_pw_reg * 32'd3125;
    assign dbl8   = n32[31];
    assign dvd32  = dbl8 ? n32 : {n32[30:0], 1'b0};
    assign zero8  = precision_reg ? (den32 == 32'd0) : (den64 == 64'd0);

    always_comb
    begin
        s8_side_next.temperature = s7_temp_reg;
        s8_side_next.fine_temp   = s7_tf_reg;
        s8_side_next.zero        = zero8;
        s8_side_next.dbl         = dbl8;
    end

    // Front pipeline registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_m1_reg   <= s1_m1_next;
            s1_m2_reg   <= s1_m2_next;
            s1_adc_reg  <= adc_p;

            s2_v1_reg   <= s2_v1_next;
            s2_m3_reg   <= s2_m3_next;
            s2_adc_reg  <= s1_adc_reg;

            s3_tf_reg   <= s3_tf_next;
            s3_adc_reg  <= s2_adc_reg;

            s4_temp_reg <= s4_temp_next;
            s4_tf_reg   <= s3_tf_reg;
            s4_aa_reg   <= aa_full[63:0];
            s4_ap5_reg  <= {{15{ap5_full[48]}}, ap5_full};
            s4_ap2_reg  <= {{15{ap2_full[48]}}, ap2_full};
            s4_sq_reg   <= q32 * q32;
            s4_ap5w_reg <= a32 * p5x;
            s4_ap2w_reg <= a32 * p2x;
            s4_adc_reg  <= s3_adc_reg;

            s5_b_reg    <= s5_b_next;
            s5_t_reg    <= t_full5[63:0];
            s5_ap2_reg  <= s4_ap2_reg;
            s5_bw_reg   <= s5_bw_next;
            s5_tw_reg   <= s5_tw_next;
            s5_ap2w_reg <= s4_ap2w_reg;
            s5_temp_reg <= s4_temp_reg;
            s5_tf_reg   <= s4_tf_reg;
            s5_adc_reg  <= s4_adc_reg;

            s6_b_reg    <= s6_b_next;
            s6_x_reg    <= s6_x_next;
            s6_bw_reg   <= s6_bw_next;
            s6_xw_reg   <= s6_xw_next;
            s6_temp_reg <= s5_temp_reg;
            s6_tf_reg   <= s5_tf_reg;
            s6_adc_reg  <= s5_adc_reg;

            s7_y_reg    <= y_full[63:0];
            s7_n_reg    <= s7_n_next;
            s7_yw_reg   <= s7_yw_next;
            s7_pw_reg   <= s7_pw_next;
            s7_temp_reg <= s6_temp_reg;
            s7_tf_reg   <= s6_tf_reg;

            s8_num_reg  <= precision_reg ? {32'd0, dvd32} : num64;
            s8_den_reg  <= precision_reg ? {32'd0, den32} : den64;
            s8_side_reg <= s8_side_next;
        end
    end

    // Shared signed divider
    logic [63:0] div_quo;
    bcomp_side_t div_side;

    bcomp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pre_vld_reg[8]),
        .num       (s8_num_reg),
        .den       (s8_den_reg),
        .side_in   (s8_side_reg),
        .out_valid (div_out_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    // Back stage 1: correction products
    logic [63:0] s64;
    logic signed [79:0] p8_full;
    logic [31:0] p32, u32;
    logic [63:0] b1_q_reg, b1_sqlo_reg, b1_p8p_reg;
    logic [31:0] b1_cross_reg, b1_p32_reg, b1_sqw_reg, b1_w2_reg;
    bcomp_side_t b1_side_reg;

    assign s64     = asr64(div_quo, 13);
    assign p8_full = $signed(div_quo) * p8s;
    assign p32     = div_side.dbl ? {div_quo[30:0], 1'b0} : div_quo[31:0];
    assign u32     = {3'd0, p32[31:3]};

    // Back stage 2: square assembly and 32-bit first term
    logic [63:0] b2_ss_next;
    logic [63:0] b2_q_reg, b2_ss_reg, b2_p8p_reg;
    logic [31:0] b2_p32_reg, b2_w1_reg, b2_w2_reg;
    bcomp_side_t b2_side_reg;

    assign b2_ss_next = b1_sqlo_reg + {b1_cross_reg[30:0], 33'd0};

    // Back stage 3: ninth-word product
    logic signed [79:0] t9_full;
    logic [63:0] b3_q_reg, b3_t_reg, b3_p8p_reg;
    logic [31:0] b3_p32_reg, b3_w1_reg, b3_w2_reg;
    bcomp_side_t b3_side_reg;

    assign t9_full = $signed(b2_ss_reg) * p9s;

    // Output stage: final sums and selection
    logic [63:0] r64;
    logic [31:0] r32, press_next;
    logic [31:0] out_temp_reg, out_tf_reg, out_press_reg;
    logic        out_inv_reg;

    assign r64 = asr64(b3_q_reg + asr64(b3_t_reg, 25) + asr64(b3_p8p_reg, 19), 8)
                 + {p7x64[59:0], 4'd0};
    assign r32 = b3_p32_reg
                 + asr32(asr32(b3_w1_reg, 12) + asr32(b3_w2_reg, 13) + p7x, 4);
    assign press_next = b3_side_reg.zero ? 32'd0 : (precision_reg ? r32 : r64[31:0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_q_reg      <= div_quo;
            b1_sqlo_reg   <= {32'd0, s64[31:0]} * {32'd0, s64[31:0]};
            b1_cross_reg  <= s64[63:32] * s64[31:0];
            b1_p8p_reg    <= p8_full[63:0];
            b1_p32_reg    <= p32;
            b1_sqw_reg    <= u32 * u32;
            b1_w2_reg     <= {2'd0, p32[31:2]} * p8x;
            b1_side_reg   <= div_side;

            b2_q_reg      <= b1_q_reg;
            b2_ss_reg     <= b2_ss_next;
            b2_p8p_reg    <= b1_p8p_reg;
            b2_p32_reg    <= b1_p32_reg;
            b2_w1_reg     <= {13'd0, b1_sqw_reg[31:13]} * p9x;
            b2_w2_reg     <= b1_w2_reg;
            b2_side_reg   <= b1_side_reg;

            b3_q_reg      <= b2_q_reg;
            b3_t_reg      <= t9_full[63:0];
            b3_p8p_reg    <= b2_p8p_reg;
            b3_p32_reg    <= b2_p32_reg;
            b3_w1_reg     <= b2_w1_reg;
            b3_w2_reg     <= b2_w2_reg;
            b3_side_reg   <= b2_side_reg;

            out_temp_reg  <= b3_side_reg.temperature;
            out_tf_reg    <= b3_side_reg.fine_temp;
            out_press_reg <= press_next;
            out_inv_reg   <= b3_side_reg.zero;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_press_reg, out_tf_reg, out_temp_reg};
    assign m_axis_tuser  = out_inv_reg;

    // Temperature recomputed from the delivered fine temperature
    logic [31:0] chk_temp;
    assign chk_temp = asr32(m_axis_tdata[63:32] * 32'd5 + 32'd128, 8);

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[95:64] == 32'd0)
        else $error("invalid result carries nonzero pressure");

    a_temp_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:0] == chk_temp)
        else $error("temperature and fine temperature out of step");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline stalled");

endmodule

[dv/barometric_sensor_compensation_tb.sv]
`timescale 1ns / 1ps

module barometric_sensor_compensation_tb;
    import bcomp_pkg::*;

    localparam int LATENCY   = 78;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] temperature;
        logic [31:0] fine_temp;
        logic [31:0] pressure;
        logic        invalid;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // raw_temp [19:0], raw_press [39:20]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // temperature, fine_temp, pressure
    logic [0:0]  m_axis_tuser;        // press_invalid [0]

    // Shadow copies of the calibration registers
    logic [47:0] sh_temp;
    logic [63:0] sh_plow;
    logic [63:0] sh_phigh;
    logic [15:0] sh_p9;
    logic        sh_prec;

    reading_t pending_readings[$];
    int       err_count = 0;
    int       cycles = 0;

    barometric_sensor_compensation dut (.*);

    always #6 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        err_count++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic logic [63:0] sdiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] sra32(logic [31:0] x, int s);
        logic signed [31:0] v;
        v = x;
        return v >>> s;
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int s);
        logic signed [63:0] v;
        v = x;
        return v >>> s;
    endfunction

    function automatic logic [63:0] w64(logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [31:0] w32(logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    // Compensate one raw pair with the shadow calibration
    function automatic reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
        reading_t r;
        logic [31:0] t1, t2, t3, d, v1, v2, tf;
        logic [63:0] a, b, p, q1, q2;
        logic [31:0] a3, b3, q3, sq, p3, x1, x2;
        t1 = {16'd0, sh_temp[15:0]};
        t2 = w32(sh_temp[31:16]);
        t3 = w32(sh_temp[47:32]);
        d  = {15'd0, adc_t[19:3]} - (t1 << 1);
        v1 = sra32(d * t2, 11);
        d  = {16'd0, adc_t[19:4]} - t1;
        v2 = sra32(sra32(d * d, 12) * t3, 14);
        tf = v1 + v2;
        r.temperature = sra32(tf * 32'd5 + 32'd128, 8);
        r.fine_temp = tf;
        r.pressure = '0;
        r.invalid = 1'b0;
        if (!sh_prec)
        begin
            a = {{32{tf[31]}}, tf} - 64'd128000;
            b = a * a * w64(sh_phigh[31:16]);
            b = b + ((a * w64(sh_phigh[15:0])) << 17);
            b = b + (w64(sh_plow[63:48]) << 35);
            a = sra64(a * a * w64(sh_plow[47:32]), 8) + ((a * w64(sh_plow[31:16])) << 12);
            a = sra64(((64'd1 << 47) + a) * {48'd0, sh_plow[15:0]}, 33);
            if (a == 0)
                r.invalid = 1'b1;
            else
            begin
                p = 64'd1048576 - {44'd0, adc_p};
                p = sdiv64(((p << 31) - b) * 64'd3125, a);
                q1 = sra64(w64(sh_p9) * sra64(p, 13) * sra64(p, 13), 25);
                q2 = sra64(w64(sh_phigh[63:48]) * p, 19);
                p = sra64(p + q1 + q2, 8) + (w64(sh_phigh[47:32]) << 4);
                r.pressure = p[31:0];
            end
        end
        else
        begin
            a3 = sra32(tf, 1) - 32'd64000;
            q3 = sra32(a3, 2);
            sq = q3 * q3;
            b3 = sra32(sq, 11) * w32(sh_phigh[31:16]);
            b3 = b3 + ((a3 * w32(sh_phigh[15:0])) << 1);
            b3 = sra32(b3, 2) + (w32(sh_plow[63:48]) << 16);
            a3 = sra32(sra32(w32(sh_plow[47:32]) * sra32(sq, 13), 3)
                       + sra32(w32(sh_plow[31:16]) * a3, 1), 18);
            a3 = sra32((32'd32768 + a3) * {16'd0, sh_plow[15:0]}, 15);
            if (a3 == 0)
                r.invalid = 1'b1;
            else
            begin
                p3 = ((32'd1048576 - {12'd0, adc_p}) - sra32(b3, 12)) * 32'd3125;
                if (p3 < 32'h80000000)
                    p3 = (p3 << 1) / a3;
                else
                    p3 = (p3 / a3) * 32'd2;
                x1 = sra32(w32(sh_p9) * (((p3 >> 3) * (p3 >> 3)) >> 13), 12);
                x2 = sra32((p3 >> 2) * w32(sh_phigh[63:48]), 13);
                r.pressure = p3 + sra32(x1 + x2 + w32(sh_phigh[47:32]), 4);
            end
        end
        return r;
    endfunction

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                report("unexpected result", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (m_axis_tdata[31:0] !== want.temperature)
                    report("temperature", m_axis_tdata[31:0], want.temperature);
                if (m_axis_tdata[63:32] !== want.fine_temp)
                    report("fine_temp", m_axis_tdata[63:32], want.fine_temp);
                if (m_axis_tdata[95:64] !== want.pressure)
                    report("pressure", m_axis_tdata[95:64], want.pressure);
                if (m_axis_tuser[0] !== want.invalid)
                    report("press_invalid", {31'd0, m_axis_tuser[0]}, {31'd0, want.invalid});
            end
        end
    end

    // Random receiver stalls
    initial
    begin
        int w;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            w = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                w = 0;
            if (w > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (w - 1) @(negedge clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_TEMP_COEFFS: sh_temp = val[47:0];
            REG_PRESS_LOW:   sh_plow = val;
            REG_PRESS_HIGH:  sh_phigh = val;
            REG_PRESS_NINE:  sh_p9 = val[15:0];
            REG_PRECISION:   sh_prec = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Send one raw pair; called and returning at a falling edge
    task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp, input bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 6) : 0;
        if (w > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rp, rt};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_readings.push_back(compensate(rt, rp));
        @(negedge clk);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    // Typical factory calibration
    task automatic load_typical(input bit prec);
        write_reg(REG_TEMP_COEFFS, {16'd50, 16'd26435, 16'd27504});
        write_reg(REG_PRESS_LOW, {16'd2855, 16'hD0D0, 16'hD61D, 16'd36477});
        write_reg(REG_PRESS_HIGH, {16'hF448, 16'd15500, 16'hFFF9, 16'd140});
        write_reg(REG_PRESS_NINE, 64'd6000);
        write_reg(REG_PRECISION, {63'd0, prec});
    endtask

    task automatic test_directed();
        logic [19:0] edges[4];
        edges = '{20'd0, 20'hFFFFF, 20'd519888, 20'd415148};
        load_typical(1'b0);
        @(negedge clk);
        foreach (edges[i])
            foreach (edges[j])
                send_reading(edges[i], edges[j], 1'b0);
        end_burst();
        drain();
        write_reg(REG_PRECISION, 64'd1);
        @(negedge clk);
        foreach (edges[i])
            send_reading(edges[i], edges[3 - i], 1'b1);
        end_burst();
        drain();
        // Zero divisor: P1 = 0 in both modes
        write_reg(REG_PRESS_LOW, 64'hFFFF_7FFF_8000_0000);
        @(negedge clk);
        send_reading(20'd519888, 20'd415148, 1'b0);
        end_burst();
        drain();
        write_reg(REG_PRECISION, 64'hFFFF_FFFF_FFFF_FFFE);
        @(negedge clk);
        send_reading(20'hFFFFF, 20'd0, 1'b0);
        end_burst();
        drain();
    endtask

    task automatic test_random(input int n, input bit typical);
        logic [63:0] v;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
            begin
                end_burst();
                drain();
                if (typical)
                begin
                    load_typical(k[6]);
                    if ($urandom_range(0, 1))
                        write_reg(REG_PRESS_NINE, {$urandom, $urandom});
                end
                else
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        v = {$urandom, $urandom};
                        if ($urandom_range(0, 4) == 0)
                            v = $urandom_range(0, 1) ? '1 : '0;
                        write_reg(r[2:0], v);
                    end
                    write_reg(REG_PRECISION, {$urandom, $urandom});
                end
                // Unknown index is ignored
                write_reg(3'd7, {$urandom, $urandom});
                @(negedge clk);
            end
            if (typical)
                send_reading(20'(380000 + $urandom_range(0, 300000)),
                             20'(250000 + $urandom_range(0, 400000)), k[3]);
            else
                send_reading(20'($urandom), 20'($urandom), k[3] | k[2]);
        end
        end_burst();
        drain();
    endtask

    initial
    begin
        sh_temp = '0;
        sh_plow = '0;
        sh_phigh = '0;
        sh_p9 = '0;
        sh_prec = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Registers at reset: every divisor is zero
        send_reading(20'd12345, 20'd54321, 1'b0);
        end_burst();
        drain();
        test_directed();
        test_random(400, 1'b1);
        test_random(400, 1'b0);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
